// File: hdl/aes_pkg.sv
`default_nettype none
package aes_pkg;
  localparam int BLOCK_W = 128;
  localparam int HALF_W  = 64;
  localparam int WORD_W  = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = 3'd4;

  localparam logic [1:0] KS_128  = 2'd0;
  localparam logic [1:0] KS_192  = 2'd1;
  localparam logic [1:0] KS_256  = 2'd2;
  localparam logic [1:0] KS_RSVD = 2'd3;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam logic [7:0] ISBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte i of the block sits in bits 127-8i .. 120-8i; column c is word c
  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    logic [1:0] src;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? 2'(c - r) : 2'(c + r);
        o[127-8*(r+4*c) -: 8] = s[127-8*(r+4*int'(src)) -: 8];
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    for (int i = 0; i < 16; i++)
      o[8*i +: 8] = inv ? ISBOX[s[8*i +: 8]] : SBOX[s[8*i +: 8]];
    return o;
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] w, input logic inv);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [31:0] o;
    for (int k = 0; k < 4; k++) begin
      a[k] = w[31-8*k -: 8];
      x2[k] = xtime(a[k]);
      x4[k] = xtime(x2[k]);
      x8[k] = xtime(x4[k]);
      m2[k] = x2[k];
      m3[k] = x2[k] ^ a[k];
      m9[k] = x8[k] ^ a[k];
      mb[k] = x8[k] ^ x2[k] ^ a[k];
      md[k] = x8[k] ^ x4[k] ^ a[k];
      me[k] = x8[k] ^ x4[k] ^ x2[k];
    end
    for (int r = 0; r < 4; r++) begin
      if (inv)
        o[31-8*r -: 8] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
      else
        o[31-8*r -: 8] = m2[r] ^ m3[(r+1)%4] ^ a[(r+2)%4] ^ a[(r+3)%4];
    end
    return o;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    for (int c = 0; c < 4; c++)
      o[127-32*c -: 32] = mix_col(s[127-32*c -: 32], inv);
    return o;
  endfunction
endpackage
`default_nettype wire

// File: hdl/aes_if.sv
`default_nettype none
interface aes_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [63:0] data_hi;
  logic [63:0] data_lo;
  modport source (output valid, req_type, data_hi, data_lo, input ready);
  modport sink (input valid, req_type, data_hi, data_lo, output ready);
endinterface

interface aes_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_hi;
  logic [63:0] result_lo;
  modport source (output valid, result_hi, result_lo, input ready);
  modport sink (input valid, result_hi, result_lo, output ready);
endinterface

interface aes_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/aes_ram.sv
`default_nettype none
module aes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hdl/aes_core.sv
`default_nettype none
// Fixed sequencer over the round-key RAM. Expansion writes one word a cycle
// (reading word i-nk through the RAM port, word i-1 from a register).
// Cipher reads one round key word a cycle and runs one round per four words.
module aes_core
  import aes_pkg::*;
#(
  parameter int MAX_RK_WORDS = 60
) (
  input  wire logic rst,
  input  wire logic clk,
  aes_req_if.sink   req,
  aes_rsp_if.source rsp,
  aes_cfg_if.sink   cfg
);
  localparam int AW = $clog2(MAX_RK_WORDS);
  localparam logic [2:0] S_IDLE = 3'd0, S_EXP = 3'd1, S_RUN = 3'd2, S_OUT = 3'd3;

  logic [2:0]   state;
  logic [1:0]   key_size;
  logic [63:0]  key_w [4];
  logic         keys_ready;
  logic         dec;
  logic [127:0] blk;
  logic [AW-1:0] idx;       // round key word index being fetched
  logic         rd_valid;
  logic [1:0]   rd_col;
  logic [127:0] rk;
  logic [31:0]  prev;
  logic [3:0]   rnd;
  logic [3:0]   rcnt;       // index within nk
  logic [7:0]   rcon;
  logic [AW-1:0] exp_cnt;

  logic [3:0]   nk;
  logic [3:0]   nr;
  logic [AW-1:0] total;
  logic         we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]  wdata, rdata;

  assign nk    = (key_size == KS_128) ? 4'd4 : (key_size == KS_192) ? 4'd6 : 4'd8;
  assign nr    = nk + 4'd6;
  assign total = AW'({nr, 2'b00} + 6'd4);

  aes_ram #(.WIDTH(WORD_W), .DEPTH(MAX_RK_WORDS)) u_rk (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // a pending key write goes first; hold the block off meanwhile
  assign cfg.ready = (state == S_IDLE);
  assign req.ready = (state == S_IDLE) && !cfg.valid;
  assign rsp.valid = (state == S_OUT);
  assign rsp.result_hi = blk[127:64];
  assign rsp.result_lo = blk[63:0];

  // expansion word generation
  logic [63:0] kw;
  logic [31:0] t, rot;
  logic        in_key;
  assign kw = key_w[exp_cnt[2:1]];
  assign in_key = exp_cnt < AW'(nk);
  assign rot = {prev[23:0], prev[31:24]};
  always_comb begin
    t = prev;
    if (rcnt == 4'd0) t = sub_word(rot) ^ {rcon, 24'h0};
    else if (nk == 4'd8 && rcnt == 4'd4) t = sub_word(prev);
  end

  // round key address: encrypt ascends, decrypt runs rounds downward
  logic [AW-1:0] fetch_addr;
  logic [3:0]    fetch_rnd;
  assign fetch_rnd = dec ? nr - 4'(idx[AW-1:2]) : 4'(idx[AW-1:2]);
  assign fetch_addr = AW'({fetch_rnd, idx[1:0]});

  always_comb begin
    we = 1'b0;
    waddr = exp_cnt;
    wdata = in_key ? (exp_cnt[0] ? kw[31:0] : kw[63:32]) : (rdata ^ t);
    raddr = fetch_addr;
    if (state == S_EXP) begin
      we = 1'b1;
      raddr = exp_cnt + AW'(1) - AW'(nk);
    end
  end

  // one round on the full block, with the last key word merged in as it arrives
  logic [127:0] rk_cur, rnd_out, sb, sr;
  assign rk_cur = {rk[127:32], rdata};
  always_comb begin
    if (!dec) begin
      sb = sub_bytes(blk, 1'b0);
      sr = shift_rows(sb, 1'b0);
      rnd_out = (rnd == nr) ? sr ^ rk_cur : mix_columns(sr, 1'b0) ^ rk_cur;
    end else begin
      sr = shift_rows(blk, 1'b1);
      sb = sub_bytes(sr, 1'b1);
      rnd_out = (rnd == nr) ? sb ^ rk_cur : mix_columns(sb ^ rk_cur, 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      key_size <= KS_128;
      key_w <= '{default: '0};
      keys_ready <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg.valid) begin
            case (cfg.index)
              REG_KEY_SIZE:  begin key_size <= (cfg.data[1:0] == KS_RSVD) ? KS_256 : cfg.data[1:0];
                                   keys_ready <= 1'b0; end
              REG_KEY_WORD0: begin key_w[0] <= cfg.data; keys_ready <= 1'b0; end
              REG_KEY_WORD1: begin key_w[1] <= cfg.data; keys_ready <= 1'b0; end
              REG_KEY_WORD2: begin key_w[2] <= cfg.data; keys_ready <= 1'b0; end
              REG_KEY_WORD3: begin key_w[3] <= cfg.data; keys_ready <= 1'b0; end
              default: ;
            endcase
          end else if (req.valid) begin
            dec <= req.req_type;
            blk <= {req.data_hi, req.data_lo};
            idx <= '0;
            rnd <= '0;
            exp_cnt <= '0;
            rcnt <= '0;
            rcon <= 8'h01;
            state <= keys_ready ? S_RUN : S_EXP;
          end
        end
        S_EXP: begin
          prev <= wdata;
          exp_cnt <= exp_cnt + AW'(1);
          if (!in_key) begin
            if (rcnt == 4'd0) rcon <= xtime(rcon);
          end
          rcnt <= (rcnt + 4'd1 == nk) ? 4'd0 : rcnt + 4'd1;
          if (exp_cnt + AW'(1) == total) begin
            keys_ready <= 1'b1;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (idx != total) begin
            idx <= idx + AW'(1);
            rd_valid <= 1'b1;
            rd_col <= idx[1:0];
          end
          if (rd_valid) begin
            rk[127-32*rd_col -: 32] <= rdata;
            if (rd_col == 2'd3) begin
              if (rnd == 4'd0) blk <= blk ^ rk_cur;
              else             blk <= rnd_out;
              rnd <= rnd + 4'd1;
              if (rnd == nr) state <= S_OUT;
            end
          end
        end
        S_OUT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hdl/aes_block_cipher_core.sv
// Channel  | Dir | Payload
// req      | in  | req_type, data_hi, data_lo
// rsp      | out | result_hi, result_lo
// cfg      | in  | index, data (key_size, key_word0..3)
// One round-key word is read per cycle from the round-key RAM (separate
// read and write ports), one round per four words. After a write to the
// key size or a key word, the first block first expands the key, one word
// per cycle. Reset is synchronous; one block at a time, the result holds
// on rsp until taken.
`default_nettype none
module aes_block_cipher_core
  import aes_pkg::*;
#(
  parameter int MAX_ROUND_KEY_WORDS = 60
) (
  input wire logic  clk,
  input wire logic  rst,
  aes_req_if.sink   req,
  aes_rsp_if.source rsp,
  aes_cfg_if.sink   cfg
);
  aes_core #(.MAX_RK_WORDS(MAX_ROUND_KEY_WORDS)) u_core (
    .rst(rst), .clk(clk), .req(req), .rsp(rsp), .cfg(cfg)
  );
endmodule
`default_nettype wire

// File: hdl/aes_checker.sv
`default_nettype none
module aes_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire logic cfg_ready
);
  a_no_in_with_out: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready) else $error("input taken while result pending");
  a_gap: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !rsp_valid) else $error("result too early");
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !cfg_ready) else $error("cfg open while busy");
  a_out_drop: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("result dropped");
endmodule

bind aes_block_cipher_core aes_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .cfg_ready(cfg.ready)
);
`default_nettype wire

// File: dv/aes_block_cipher_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module aes_block_cipher_checker
  import aes_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  aes_req_if.sink  req_mon,
  aes_rsp_if.sink  rsp_mon,
  aes_cfg_if.sink  cfg_mon,
  output int       fail_count,
  output int       pending
);

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  logic [1:0]  key_len_code;
  logic [63:0] key_reg [4];
  logic [31:0] sched [60];
  logic        sched_valid;
  int          rounds;
  block_t      cipher_q [$];

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return r;
  endfunction

  function automatic logic [7:0] gf_inv(input logic [7:0] x);
    logic [7:0] r;
    r = 1;
    for (int i = 0; i < 254; i++) r = gf_mul(r, x);
    return r;
  endfunction

  function automatic logic [7:0] rotl(input logic [7:0] x, input int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  logic [7:0] fwd_tab [256];
  logic [7:0] inv_tab [256];
  initial begin
    logic [7:0] b;
    for (int i = 0; i < 256; i++) begin
      b = gf_inv(8'(i));
      fwd_tab[i] = b ^ rotl(b, 1) ^ rotl(b, 2) ^ rotl(b, 3) ^ rotl(b, 4) ^ 8'h63;
    end
    for (int i = 0; i < 256; i++) inv_tab[fwd_tab[i]] = 8'(i);
  end

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {fwd_tab[w[31:24]], fwd_tab[w[23:16]], fwd_tab[w[15:8]], fwd_tab[w[7:0]]};
  endfunction

  task automatic build_schedule();
    int ks, nk, total;
    logic [31:0] t;
    logic [7:0] rc;
    ks = (key_len_code == KS_RSVD) ? 2 : int'(key_len_code);
    nk = 4 + 2 * ks;
    rounds = nk + 6;
    total = 4 * (rounds + 1);
    for (int i = 0; i < nk; i++)
      sched[i] = i[0] ? key_reg[i / 2][31:0] : key_reg[i / 2][63:32];
    rc = 8'h01;
    for (int i = nk; i < total; i++) begin
      t = sched[i - 1];
      if (i % nk == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end else if (nk > 6 && i % nk == 4) begin
        t = sbox_word(t);
      end
      sched[i] = sched[i - nk] ^ t;
    end
    sched_valid = 1;
  endtask

  function automatic block_t run_cipher(input logic dec, input block_t blk);
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] col [4];
    logic [7:0] m [4];
    int rd;
    for (int i = 0; i < 8; i++) begin
      st[i] = blk.hi[63 - 8 * i -: 8];
      st[i + 8] = blk.lo[63 - 8 * i -: 8];
    end
    if (dec) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else m = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int step = 0; step <= rounds; step++) begin
      rd = dec ? rounds - step : step;
      if (step > 0) begin
        tmp = st;
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++)
            if (dec) st[r + 4 * ((c + r) % 4)] = inv_tab[tmp[r + 4 * c]];
            else st[r + 4 * c] = fwd_tab[tmp[r + 4 * ((c + r) % 4)]];
        if (!dec && step < rounds) begin
          for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) col[r] = st[r + 4 * c];
            for (int r = 0; r < 4; r++)
              st[r + 4 * c] = gf_mul(m[(4 - r) % 4], col[0]) ^ gf_mul(m[(5 - r) % 4], col[1])
                ^ gf_mul(m[(6 - r) % 4], col[2]) ^ gf_mul(m[(7 - r) % 4], col[3]);
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          st[r + 4 * c] ^= sched[rd * 4 + c][31 - 8 * r -: 8];
      // inverse mix follows the key add on the way back
      if (dec && step > 0 && step < rounds) begin
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) col[r] = st[r + 4 * c];
          for (int r = 0; r < 4; r++)
            st[r + 4 * c] = gf_mul(m[(4 - r) % 4], col[0]) ^ gf_mul(m[(5 - r) % 4], col[1])
              ^ gf_mul(m[(6 - r) % 4], col[2]) ^ gf_mul(m[(7 - r) % 4], col[3]);
        end
      end
    end
    for (int i = 0; i < 8; i++) begin
      run_cipher.hi[63 - 8 * i -: 8] = st[i];
      run_cipher.lo[63 - 8 * i -: 8] = st[i + 8];
    end
  endfunction

  assign pending = cipher_q.size();

  always @(posedge clk) begin
    block_t got, want;
    if (rst) begin
      key_len_code = KS_128;
      key_reg = '{default: '0};
      sched_valid = 0;
      cipher_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_KEY_SIZE: key_len_code = cfg_mon.data[1:0];
          REG_KEY_WORD0, REG_KEY_WORD1, REG_KEY_WORD2, REG_KEY_WORD3:
            key_reg[2'(cfg_mon.index - REG_KEY_WORD0)] = cfg_mon.data;
          default: ;
        endcase
        if (cfg_mon.index <= REG_KEY_WORD3) sched_valid = 0;
      end
      if (req_mon.valid && req_mon.ready) begin
        if (!sched_valid) build_schedule();
        cipher_q.push_back(run_cipher(req_mon.req_type, {req_mon.data_hi, req_mon.data_lo}));
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = {rsp_mon.result_hi, rsp_mon.result_lo};
        if (cipher_q.size() == 0) begin
          $display("%0t: unexpected beat, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = cipher_q.pop_front();
          if (got.hi !== want.hi) begin
            $display("%0t: result_hi expected %h actual %h", $time, want.hi, got.hi);
            fail_count <= fail_count + 1;
          end else if (got.lo !== want.lo) begin
            $display("%0t: result_lo expected %h actual %h", $time, want.lo, got.lo);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: dv/tb_aes_block_cipher_core.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_aes_block_cipher_core
  import aes_pkg::*;
;

  localparam int STALL_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  int   fail_count;
  int   pending;
  int   src_idle_pct = 24;
  int   dst_idle_pct = 79;
  bit   dst_hold;
  int   idle_cycles;

  aes_req_if req ();
  aes_rsp_if rsp ();
  aes_cfg_if cfg ();

  always #2 clk = ~clk;

  aes_block_cipher_core u_top (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));
  aes_block_cipher_checker u_chk (.clk(clk), .rst(rst), .req_mon(req), .rsp_mon(rsp),
    .cfg_mon(cfg), .fail_count(fail_count), .pending(pending));

  initial begin
    req.valid = 0; req.req_type = 0; req.data_hi = 0; req.data_lo = 0;
    cfg.valid = 0; cfg.index = REG_KEY_SIZE; cfg.data = 0;
    rsp.ready = 0;
  end

  always @(negedge clk) begin
    if (rst || dst_hold) rsp.ready <= 0;
    else rsp.ready <= ($urandom_range(99) >= dst_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_key_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg.valid <= 1; cfg.index <= idx; cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic load_key(input logic [1:0] ks, input logic [63:0] k0, k1, k2, k3);
    drain();
    write_key_reg(REG_KEY_SIZE, {62'h0, ks});
    write_key_reg(REG_KEY_WORD0, k0);
    write_key_reg(REG_KEY_WORD1, k1);
    write_key_reg(REG_KEY_WORD2, k2);
    write_key_reg(REG_KEY_WORD3, k3);
  endtask

  task automatic send_block(input logic dir, input logic [63:0] hi, lo);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) @(negedge clk);
    req.valid <= 1; req.req_type <= dir; req.data_hi <= hi; req.data_lo <= lo;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    req.valid <= 0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick64();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;
    // reset key (all zero, 128 bit) first
    send_block(1'b0, '0, '0);
    send_block(1'b1, '1, '1);
    // standard test vectors for each key length
    load_key(KS_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 0, 0);
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    load_key(KS_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617, 0);
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1'b1, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
    load_key(KS_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
    // unused size code behaves as 256 bit
    load_key(KS_RSVD, '1, '1, '1, '1);
    send_block(1'b0, '1, '1);
    send_block(1'b1, '0, '0);
    // out-of-range index must not disturb the key
    drain();
    write_key_reg(3'd5, rand64());
    write_key_reg(3'd7, '1);
    send_block(1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210);
    // single register change triggers re-expansion
    drain();
    write_key_reg(REG_KEY_WORD1, '0);
    send_block(1'b1, '0, '1);

    // receiver stalls long while sender keeps offering
    dst_hold = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        dst_hold = 0;
      end
      for (int i = 0; i < 6; i++) send_block(1'($urandom_range(1)), rand64(), rand64());
    join
    // sender pauses until everything is back
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 79 : 0;
      dst_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 24 : 0;
      for (int k = 0; k < 7; k++) begin
        load_key((k == 0) ? KS_128 : (k == 1) ? KS_192 : (k == 2) ? KS_256 :
                 2'($urandom_range(3)),
                 pick64(), pick64(), pick64(), pick64());
        for (int i = 0; i < 48; i++) send_block(1'($urandom_range(1)), pick64(), pick64());
      end
    end

    drain();
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
hdl/aes_pkg.sv
hdl/aes_if.sv
hdl/aes_ram.sv
hdl/aes_core.sv
hdl/aes_block_cipher_core.sv
hdl/aes_checker.sv
dv/aes_block_cipher_checker.sv
dv/tb_aes_block_cipher_core.sv
